// ===== rtl/core/evr_pkg.sv =====
// shared constants for the encoder angle vector rotator
package evr_pkg;

    // sine table entries are unsigned q0.15 magnitudes
    localparam int SIN_W    = 15;
    localparam int SIN_FRAC = 15;

    // table generation: pi/2 in unsigned q2.30 and the taylor series through x^17
    localparam int          Q30_SHIFT    = 30;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 8;

    // (2n)(2n+1) for n = 1..8
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    localparam logic [SIN_W-1:0] SIN_MAX = '1;

endpackage

// ===== rtl/core/evr_if.sv =====
// valid/ready channels for commands, results and the zero point write

interface evr_cmd_if #(
    parameter int ANGLE_BITS = 13,
    parameter int VEL_BITS   = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_BITS-1:0]  vel_x;
    logic signed [VEL_BITS-1:0]  vel_y;
    logic [ANGLE_BITS-1:0]       yaw_angle;

    modport source (output valid, vel_x, vel_y, yaw_angle, input ready);
    modport sink   (input valid, vel_x, vel_y, yaw_angle, output ready);
endinterface

interface evr_rot_if #(
    parameter int VEL_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_BITS-1:0]  rot_x;
    logic signed [VEL_BITS-1:0]  rot_y;
    logic                        saturated;

    modport source (output valid, rot_x, rot_y, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, saturated, output ready);
endinterface

interface evr_cfg_if #(
    parameter int ANGLE_BITS = 13
);
    logic                        valid;
    logic                        ready;
    logic [ANGLE_BITS-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/encoder_angle_vector_rotator.sv =====
// rotates a planar velocity command into the chassis frame using the yaw encoder angle
//
// Each command beat (vel_x, vel_y, yaw_angle) is rotated by minus the yaw angle
// b = (yaw_angle - zero_point) mod 2^ANGLE_BITS, giving rot_x = x cos b + y sin b and
// rot_y = -x sin b + y cos b in signed Q4.12, rounded half up and saturated to VEL_BITS
// bits; saturated flags a clipped component. Sine and cosine come from a quarter-wave
// Q0.15 ROM of 2^(ANGLE_BITS-2)+1 entries that is built at elaboration, so there is no
// clearing or loading pass after reset. The block takes one command per clock unless
// o_rot.ready holds back a full pipeline. A beat passes in order through an input
// register (angle offset), the registered ROM read (two ports, sine and cosine), the
// multiplier register and the result register. Every stage stalls only when the stage
// after it is full and stalled, so a waiting result does not block new commands while
// bubbles remain.
// zero_point resets to 0 and is written through i_cfg; write it only while idle.

module encoder_angle_vector_rotator
    import evr_pkg::*;
#(
    parameter int ANGLE_BITS = 13,
    parameter int VEL_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    evr_cmd_if.sink       i_cmd,
    evr_cfg_if.sink       i_cfg,
    evr_rot_if.source     o_rot
);

    localparam int QB      = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int PROD_W  = VEL_BITS + SIN_W + 1;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [QB:0]             QUARTER_IDX = (QB + 1)'(QUARTER);
    localparam logic [ANGLE_BITS-1:0]   QUARTER_ANG = ANGLE_BITS'(QUARTER);
    localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (SIN_FRAC - 1);
    localparam logic signed [SUM_W-1:0] VEL_MAX     = (SUM_W'(1) << (VEL_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] VEL_MIN     = -(SUM_W'(1) << (VEL_BITS - 1));

    typedef logic [SIN_W-1:0] t_sine_rom [QUARTER + 1];

    // sine of x (q2.30, 0..pi/2) by taylor series, rounded to q0.15
    function automatic logic [SIN_W-1:0] quarter_sine(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] acc;
        x2   = (x * x) >> Q30_SHIFT;
        term = x;
        acc  = $signed({2'b00, x});
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = (term * x2) >> Q30_SHIFT;
            term = term / TAYLOR_DIV[n - 1];
            if ((n & 1) != 0) begin
                acc = acc - $signed({2'b00, term});
            end else begin
                acc = acc + $signed({2'b00, term});
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        acc = (acc + 66'sd16384) >>> SIN_FRAC;
        if (acc > 66'sd32767) begin
            acc = 66'sd32767;
        end
        return acc[SIN_W-1:0];
    endfunction

    function automatic t_sine_rom build_rom();
        t_sine_rom   rom;
        logic [63:0] theta;
        for (int k = 0; k <= QUARTER; k++) begin
            theta  = (64'(k) * HALF_PI_Q30 + 64'(QUARTER >> 1)) >> QB;
            rom[k] = quarter_sine(theta);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // round half up by an arithmetic shift, then clip; msb of the result is the clip flag
    function automatic logic [VEL_BITS:0] round_clip(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = (s + ROUND_HALF) >>> SIN_FRAC;
        if (v > VEL_MAX) begin
            return {1'b1, VEL_MAX[VEL_BITS-1:0]};
        end else if (v < VEL_MIN) begin
            return {1'b1, VEL_MIN[VEL_BITS-1:0]};
        end
        return {1'b0, v[VEL_BITS-1:0]};
    endfunction

    // zero point register
    logic [ANGLE_BITS-1:0] r_zero_point;

    // stage valids and load enables
    logic r_v0, r_v1, r_v2, r_v3;
    logic en0, en1, en2, en3;

    // stage 0: operands and angle relative to the zero point
    logic signed [VEL_BITS-1:0] r_s0_x, r_s0_y;
    logic [ANGLE_BITS-1:0]      r_s0_angle;
    logic [ANGLE_BITS-1:0]      n_angle;

    // stage 1: rom outputs with quadrant signs
    logic signed [VEL_BITS-1:0] r_s1_x, r_s1_y;
    logic [SIN_W-1:0]           r_s1_sin_mag, r_s1_cos_mag;
    logic                       r_s1_sin_neg, r_s1_cos_neg;

    // stage 2: the four products
    logic signed [PROD_W-1:0]   r_s2_xc, r_s2_ys, r_s2_yc, r_s2_xs;

    // stage 3: result register
    logic signed [VEL_BITS-1:0] r_s3_x, r_s3_y;
    logic                       r_s3_sat;

    // rom addressing
    logic [ANGLE_BITS-1:0] cos_angle;
    logic [QB-1:0]         sin_off, cos_off;
    logic [QB:0]           sin_idx, cos_idx;

    // signed trig values and sums
    logic signed [SIN_W:0]    sin_s, cos_s;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [VEL_BITS:0]        clip_x, clip_y;

    // a stage loads when it is empty or its contents move on
    assign en3 = !r_v3 || o_rot.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign i_cmd.ready = en0;
    assign i_cfg.ready = 1'b1;

    assign o_rot.valid     = r_v3;
    assign o_rot.rot_x     = r_s3_x;
    assign o_rot.rot_y     = r_s3_y;
    assign o_rot.saturated = r_s3_sat;

    assign n_angle = i_cmd.yaw_angle - r_zero_point;

    // quarter-wave folding: odd quadrants mirror the index, upper half negates
    always_comb begin
        cos_angle = r_s0_angle + QUARTER_ANG;
        sin_off   = r_s0_angle[QB-1:0];
        cos_off   = cos_angle[QB-1:0];
        sin_idx   = r_s0_angle[QB] ? (QUARTER_IDX - {1'b0, sin_off}) : {1'b0, sin_off};
        cos_idx   = cos_angle[QB]  ? (QUARTER_IDX - {1'b0, cos_off}) : {1'b0, cos_off};
    end

    always_comb begin
        sin_s = r_s1_sin_neg ? -$signed({1'b0, r_s1_sin_mag}) : $signed({1'b0, r_s1_sin_mag});
        cos_s = r_s1_cos_neg ? -$signed({1'b0, r_s1_cos_mag}) : $signed({1'b0, r_s1_cos_mag});
    end

    always_comb begin
        sum_x  = SUM_W'(r_s2_xc) + SUM_W'(r_s2_ys);
        sum_y  = SUM_W'(r_s2_yc) - SUM_W'(r_s2_xs);
        clip_x = round_clip(sum_x);
        clip_y = round_clip(sum_y);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_point <= '0;
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_zero_point <= i_cfg.data;
            end
            if (en0) r_v0 <= i_cmd.valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // datapath, including the registered rom read
    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s0_x     <= i_cmd.vel_x;
            r_s0_y     <= i_cmd.vel_y;
            r_s0_angle <= n_angle;
        end
        if (en1) begin
            r_s1_x       <= r_s0_x;
            r_s1_y       <= r_s0_y;
            r_s1_sin_mag <= SINE_ROM[sin_idx];
            r_s1_cos_mag <= SINE_ROM[cos_idx];
            r_s1_sin_neg <= r_s0_angle[ANGLE_BITS-1];
            r_s1_cos_neg <= cos_angle[ANGLE_BITS-1];
        end
        if (en2) begin
            r_s2_xc <= PROD_W'(r_s1_x) * PROD_W'(cos_s);
            r_s2_ys <= PROD_W'(r_s1_y) * PROD_W'(sin_s);
            r_s2_yc <= PROD_W'(r_s1_y) * PROD_W'(cos_s);
            r_s2_xs <= PROD_W'(r_s1_x) * PROD_W'(sin_s);
        end
        if (en3) begin
            r_s3_x   <= clip_x[VEL_BITS-1:0];
            r_s3_y   <= clip_y[VEL_BITS-1:0];
            r_s3_sat <= clip_x[VEL_BITS] | clip_y[VEL_BITS];
        end
    end

    // a zero sine only happens on an axis, where the cosine is full scale
    a_axis_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_s1_sin_mag == '0) |-> (r_s1_cos_mag == SIN_MAX))
        else $error("sine is zero but cosine is not full scale");

    // a clipped beat carries a rail value in at least one component
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_s3_sat) |-> (r_s3_x == VEL_MAX[VEL_BITS-1:0]
                             || r_s3_x == VEL_MIN[VEL_BITS-1:0]
                             || r_s3_y == VEL_MAX[VEL_BITS-1:0]
                             || r_s3_y == VEL_MIN[VEL_BITS-1:0]))
        else $error("saturation flag without a rail value");

    // an empty result register always takes the product stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_v3) |=> r_v3)
        else $error("product beat lost before the result register");

    // a beat in the rom stage always moves on into an empty product stage
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r_v2) |=> r_v2)
        else $error("rom beat lost before the product stage");

endmodule
